[hdl/register_alu_condition_unit_defines.svh]
// Assertion macros for the register ALU with condition code.
// Included by every RTL file that carries concurrent assertions.
`ifndef REGISTER_ALU_CONDITION_UNIT_DEFINES_SVH
`define REGISTER_ALU_CONDITION_UNIT_DEFINES_SVH

// Same-cycle implication, checked on rising clock, quiet in reset
`define RACU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("racu assertion failed");

// Next-cycle implication, checked on rising clock, quiet in reset
`define RACU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("racu assertion failed");

`endif

[hdl/racu_pkg.sv]
// Package for the register ALU with condition code: opcodes, condition
// codes, word layout and parameter defaults. No dependencies.
package racu_pkg;

   // Parameter defaults
   localparam int unsigned NUM_REGS_DEF   = 16;
   localparam int unsigned DATA_WIDTH_DEF = 32;

   // Fixed field widths of the stream words
   localparam int unsigned KIND_W    = 5;
   localparam int unsigned REGIDX_W  = 4;
   localparam int unsigned OPERAND_W = 32;
   localparam int unsigned STORE_W   = 32;
   localparam int unsigned COND_W    = 2;

   // Request word: dest_reg, src_reg, operand_value (kind rides on tuser)
   localparam int unsigned REQ_DEST_LO = 0;
   localparam int unsigned REQ_SRC_LO  = REQ_DEST_LO + REGIDX_W;
   localparam int unsigned REQ_OPND_LO = REQ_SRC_LO + REGIDX_W;
   localparam int unsigned REQ_BITS    = REQ_OPND_LO + OPERAND_W;
   localparam int unsigned REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;

   // Response word: store_value, cond_code, branch_taken
   localparam int unsigned RSP_BITS    = STORE_W + COND_W + 1;
   localparam int unsigned RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;

   // Instruction kinds
   localparam logic [KIND_W-1:0] KIND_A  = 5'd0;
   localparam logic [KIND_W-1:0] KIND_AR = 5'd1;
   localparam logic [KIND_W-1:0] KIND_S  = 5'd2;
   localparam logic [KIND_W-1:0] KIND_SR = 5'd3;
   localparam logic [KIND_W-1:0] KIND_M  = 5'd4;
   localparam logic [KIND_W-1:0] KIND_MR = 5'd5;
   localparam logic [KIND_W-1:0] KIND_D  = 5'd6;
   localparam logic [KIND_W-1:0] KIND_DR = 5'd7;
   localparam logic [KIND_W-1:0] KIND_C  = 5'd8;
   localparam logic [KIND_W-1:0] KIND_CR = 5'd9;
   localparam logic [KIND_W-1:0] KIND_L  = 5'd10;
   localparam logic [KIND_W-1:0] KIND_LA = 5'd11;
   localparam logic [KIND_W-1:0] KIND_LR = 5'd12;
   localparam logic [KIND_W-1:0] KIND_ST = 5'd13;
   localparam logic [KIND_W-1:0] KIND_J  = 5'd14;
   localparam logic [KIND_W-1:0] KIND_JZ = 5'd15;
   localparam logic [KIND_W-1:0] KIND_JP = 5'd16;
   localparam logic [KIND_W-1:0] KIND_JN = 5'd17;

   // Condition codes
   localparam logic [COND_W-1:0] COND_ZERO = 2'd0;
   localparam logic [COND_W-1:0] COND_POS  = 2'd1;
   localparam logic [COND_W-1:0] COND_NEG  = 2'd2;
   localparam logic [COND_W-1:0] COND_ERR  = 2'd3;

   // Condition update selector
   typedef enum logic [1:0] {
      CC_KEEP,
      CC_RES,
      CC_SET
   } cc_sel_type;

endpackage

[hdl/register_alu_condition_unit.sv]
// Register ALU with condition code: register file memory, sequencer,
// shift-add multiplier and restoring divider. Depends on racu_pkg and the defines header.
//
//   channel | dir | word                      | sideband
//   req     | in  | dest, src, operand_value  | tuser = kind
//   rsp     | out | store_value, cond, taken  | none
//
// One item at a time: a simple op runs the execute and done states and then
// registers its result word, and the next word is taken back in idle; multiply
// adds a shift-add loop state, a nonzero divide a loop state and a sign-fix state.
// Reset clears the condition; registers read as zero through per-entry valid bits.
// A stalled result holds in the output register; the next item runs and waits
// in the done state, with req_tready low, until that register frees.
`include "register_alu_condition_unit_defines.svh"

module register_alu_condition_unit #(
   parameter int unsigned NUM_REGS   = racu_pkg::NUM_REGS_DEF,
   parameter int unsigned DATA_WIDTH = racu_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [3:0] dest_reg, [7:4] src_reg, [39:8] operand_value
   input  logic [racu_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [4:0] kind
   input  logic [racu_pkg::KIND_W-1:0]       req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] store_value, [33:32] cond_code, [34] branch_taken, [39:35] zero
   output logic [racu_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import racu_pkg::*;

   localparam int unsigned AW = $clog2(NUM_REGS);
   localparam int unsigned CW = $clog2(DATA_WIDTH);

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_FIX  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   // Register index folded modulo the file depth (16-entry lookup)
   function automatic logic [AW-1:0] reg_idx(input logic [REGIDX_W-1:0] v);
      logic [AW-1:0] r;
      r = '0;
      for (int k = 0; k < 16; k++) begin
         if (v == REGIDX_W'(k)) r = AW'(k % NUM_REGS);
      end
      return r;
   endfunction

   function automatic logic [COND_W-1:0] sign_code(input logic [DATA_WIDTH-1:0] x);
      logic [COND_W-1:0] c;
      if (x == '0) c = COND_ZERO;
      else if (x[DATA_WIDTH-1]) c = COND_NEG;
      else c = COND_POS;
      return c;
   endfunction

   // Request unpack
   logic [REGIDX_W-1:0]         req_dest;
   logic [REGIDX_W-1:0]         req_src;
   logic signed [OPERAND_W-1:0] req_operand;
   logic                        req_accept;
   logic [AW-1:0]               req_didx;
   logic [AW-1:0]               req_sidx;

   assign req_dest    = req_tdata[REQ_DEST_LO +: REGIDX_W];
   assign req_src     = req_tdata[REQ_SRC_LO +: REGIDX_W];
   assign req_operand = req_tdata[REQ_OPND_LO +: OPERAND_W];
   assign req_accept  = req_tvalid && req_tready;
   assign req_didx    = reg_idx(req_dest);
   assign req_sidx    = reg_idx(req_src);

   // State and datapath registers
   logic [2:0]            state_ff, state_in;
   logic [KIND_W-1:0]     kind_ff;
   logic [AW-1:0]         didx_ff;
   logic [DATA_WIDTH-1:0] opnd_ff;
   logic [COND_W-1:0]     cond_ff, cond_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic [DATA_WIDTH-1:0] opa_ff, opa_in;
   logic [DATA_WIDTH-1:0] opb_ff, opb_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic                  neg_ff, neg_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  wr_ff, wr_in;
   cc_sel_type            cc_sel_ff, cc_sel_in;
   logic [COND_W-1:0]     cc_val_ff, cc_val_in;
   logic                  taken_ff, taken_in;

   // Register file memory and its valid bits
   logic [DATA_WIDTH-1:0] rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0]   rf_ok_ff;
   logic [DATA_WIDTH-1:0] rd_a_ff, rd_b_ff;
   logic                  ok_a_ff, ok_b_ff;

   // Response register
   logic                    rsp_valid_ff;
   logic [STORE_W-1:0]      rsp_store_ff;
   logic [COND_W-1:0]       rsp_cond_ff;
   logic                    rsp_taken_ff;
   logic                    rsp_load;
   logic                    mem_we;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign mem_we     = rsp_load && wr_ff;

   // Operands as read from the file
   logic [DATA_WIDTH-1:0] a_op, b_reg, second;
   logic                  reg_form;
   logic [DATA_WIDTH-1:0] a_mag, s_mag;
   logic [DATA_WIDTH+1:0] div_diff;
   logic                  last_step;

   assign a_op     = ok_a_ff ? rd_a_ff : '0;
   assign b_reg    = ok_b_ff ? rd_b_ff : '0;
   assign reg_form = (kind_ff < KIND_L) && kind_ff[0];
   assign second   = reg_form ? b_reg : opnd_ff;
   assign a_mag    = a_op[DATA_WIDTH-1] ? (~a_op + 1'b1) : a_op;
   assign s_mag    = second[DATA_WIDTH-1] ? (~second + 1'b1) : second;
   assign div_diff = {1'b0, rem_ff, opa_ff[DATA_WIDTH-1]} - {2'b00, opb_ff};
   assign last_step = (cnt_ff == CW'(DATA_WIDTH - 1));

   // Sequencer and execute
   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      wr_in     = wr_ff;
      cc_sel_in = cc_sel_ff;
      cc_val_in = cc_val_ff;
      taken_in  = taken_ff;
      cond_in   = cond_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            res_in    = a_op;
            wr_in     = 1'b0;
            cc_sel_in = CC_KEEP;
            cc_val_in = cond_ff;
            taken_in  = 1'b0;
            cnt_in    = '0;
            state_in  = S_DONE;
            unique case (kind_ff)
               KIND_A, KIND_AR: begin
                  res_in    = a_op + second;
                  wr_in     = 1'b1;
                  cc_sel_in = CC_RES;
               end
               KIND_S, KIND_SR: begin
                  res_in    = a_op - second;
                  wr_in     = 1'b1;
                  cc_sel_in = CC_RES;
               end
               KIND_M, KIND_MR: begin
                  res_in    = '0;
                  opa_in    = a_op;
                  opb_in    = second;
                  wr_in     = 1'b1;
                  cc_sel_in = CC_RES;
                  state_in  = S_MUL;
               end
               KIND_D, KIND_DR: begin
                  if (second == '0) begin
                     cc_sel_in = CC_SET;
                     cc_val_in = COND_ERR;
                  end else begin
                     opa_in    = a_mag;
                     opb_in    = s_mag;
                     rem_in    = '0;
                     neg_in    = a_op[DATA_WIDTH-1] ^ second[DATA_WIDTH-1];
                     wr_in     = 1'b1;
                     cc_sel_in = CC_RES;
                     state_in  = S_DIV;
                  end
               end
               KIND_C, KIND_CR: begin
                  cc_sel_in = CC_SET;
                  if ($signed(a_op) < $signed(second)) cc_val_in = COND_NEG;
                  else if (a_op == second) cc_val_in = COND_ZERO;
                  else cc_val_in = COND_POS;
               end
               KIND_L, KIND_LA: begin
                  res_in = opnd_ff;
                  wr_in  = 1'b1;
               end
               KIND_LR: begin
                  res_in = b_reg;
                  wr_in  = 1'b1;
               end
               KIND_J:  taken_in = 1'b1;
               KIND_JZ: taken_in = (cond_ff == COND_ZERO);
               KIND_JP: taken_in = (cond_ff == COND_POS);
               KIND_JN: taken_in = (cond_ff == COND_NEG);
               default: begin
                  // store and unused codes only report the register
                  res_in = a_op;
               end
            endcase
         end
         S_MUL: begin
            // shift-add, one multiplier bit per cycle, low bits kept
            if (opb_ff[0]) res_in = res_ff + opa_ff;
            opa_in = {opa_ff[DATA_WIDTH-2:0], 1'b0};
            opb_in = {1'b0, opb_ff[DATA_WIDTH-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (last_step) state_in = S_DONE;
         end
         S_DIV: begin
            // restoring divide on magnitudes, quotient shifts into opa
            if (!div_diff[DATA_WIDTH+1]) begin
               rem_in = div_diff[DATA_WIDTH-1:0];
               opa_in = {opa_ff[DATA_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[DATA_WIDTH-2:0], opa_ff[DATA_WIDTH-1]};
               opa_in = {opa_ff[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (last_step) state_in = S_FIX;
         end
         S_FIX: begin
            res_in   = neg_ff ? (~opa_ff + 1'b1) : opa_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               unique case (cc_sel_ff)
                  CC_RES:  cond_in = sign_code(res_ff);
                  CC_SET:  cond_in = cc_val_ff;
                  default: cond_in = cond_ff;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cond_ff  <= COND_ZERO;
      end else begin
         state_ff <= state_in;
         cond_ff  <= cond_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff <= req_tuser;
         didx_ff <= req_didx;
         opnd_ff <= DATA_WIDTH'(req_operand);
      end
      res_ff    <= res_in;
      opa_ff    <= opa_in;
      opb_ff    <= opb_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
      wr_ff     <= wr_in;
      cc_sel_ff <= cc_sel_in;
      cc_val_ff <= cc_val_in;
      taken_ff  <= taken_in;
   end

   // Register file: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) rf_mem[didx_ff] <= res_ff;
      if (req_accept) begin
         rd_a_ff <= rf_mem[req_didx];
         rd_b_ff <= rf_mem[req_sidx];
      end
   end

   // Valid bits: unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_ok_ff <= '0;
      end else if (mem_we) begin
         rf_ok_ff[didx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ok_a_ff <= rf_ok_ff[req_didx];
         ok_b_ff <= rf_ok_ff[req_sidx];
      end
   end

   // Response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_store_ff <= STORE_W'(res_ff);
         rsp_cond_ff  <= cond_in;
         rsp_taken_ff <= taken_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_taken_ff, rsp_cond_ff, rsp_store_ff};

   // Checks
   `RACU_ASSERT_NEXT(a_accept_exec, clock, reset, req_accept, state_ff == S_EXEC)
   `RACU_ASSERT_NOW(a_no_write_on_accept, clock, reset, req_accept, !mem_we)
   `RACU_ASSERT_NOW(a_div_zero_no_write, clock, reset,
      (state_ff == S_DONE) && (cc_sel_ff == CC_SET) && (cc_val_ff == COND_ERR), !wr_ff)
   `RACU_ASSERT_NOW(a_taken_jump_only, clock, reset,
      (state_ff == S_DONE) && taken_ff,
      (kind_ff == KIND_J) || (kind_ff == KIND_JZ) || (kind_ff == KIND_JP) ||
      (kind_ff == KIND_JN))
   `RACU_ASSERT_NEXT(a_iter_start, clock, reset,
      (state_ff == S_EXEC) && ((state_in == S_MUL) || (state_in == S_DIV)), cnt_ff == '0)

endmodule
